[rtl/msdw_pkg.sv]
`default_nettype none
package msdw_pkg;

    localparam logic signed [63:0] SENTINEL = -64'sd4000000000000000;

    localparam logic [1:0] REG_MAX_WINDOWS = 2'd0;
    localparam logic [1:0] REG_MIN_LEN     = 2'd1;
    localparam logic [1:0] REG_MAX_LEN     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_RD1,
        ST_RD2,
        ST_PI,
        ST_TCHK,
        ST_TCMP,
        ST_PUSH,
        ST_HCHK,
        ST_HCMP,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/max_sum_disjoint_windows_core.sv]
`default_nettype none
// Best total of one to max_windows disjoint runs, each min_len to max_len long.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// The slave stream carries one signed element per transaction; s_tlast marks
// the final element. Loading accepts one element per cycle, and elements past
// MAX_ELEMENTS are dropped. After the final element the block runs a dynamic
// program row by row; each row begins with a setup state, and each element of
// a row steps through prefix reads, tail pops, a push, head pops and an update,
// all set by the single read port of the prefix, row and queue memories. It
// goes straight to the done state when no run fits or max_windows is zero.
// s_tready is low while it runs. The single result leaves on the master
// stream, with the total in m_tdata and the no-fit flag in m_tuser. A stalled
// receiver holds the result in the output register; loading of the next
// sequence goes on, and its result waits inside the core, with s_tready low,
// until the register drains.
// Reset clears the counters, the output valid flag and the configuration
// (all three registers to 1). Memories are not cleared.
module max_sum_disjoint_windows_core #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_WIDTH  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic        s_tlast,   // last_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // answer_sum, zero padding
    output logic             m_tuser    // none_fits
);

    localparam int DEPTH = MAX_ELEMENTS + 1;
    localparam int CW    = $clog2(DEPTH);
    localparam int XW    = ((CW > 11) ? CW : 11) + 1;
    localparam int QW    = CW + 64;

    msdw_pkg::state_t state_reg, state_next;

    logic [10:0] max_windows_reg, min_len_reg, max_len_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [63:0] psum_reg, psum_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] add_reg, add_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [10:0] k_reg, k_next;
    logic bank_reg, bank_next;
    logic signed [63:0] v_reg, v_next;
    logic signed [63:0] pi_reg, pi_next;
    logic signed [63:0] hv_reg, hv_next;
    logic hnon_reg, hnon_next;
    logic signed [63:0] curprev_reg, curprev_next;
    logic signed [63:0] ans_reg, ans_next;
    logic paddr0_reg, paddr0_next;
    logic ovalid_reg, ovalid_next;
    logic signed [63:0] odata_reg, odata_next;

    logic p_we;
    logic [CW-1:0] p_waddr, p_raddr;
    logic [63:0] p_wdata, p_rdata;
    logic r_we;
    logic [63:0] ra_rdata, rb_rdata;
    logic q_we;
    logic [QW-1:0] q_wdata, q_rdata;
    logic [CW-1:0] q_addr;

    logic [10:0] lo;
    logic signed [63:0] value_ext;
    logic signed [63:0] psum_add;
    logic signed [63:0] p_val, prev_val, q_val, cand, new_cur;
    logic [CW-1:0] q_idx;
    logic [CW-1:0] n_load;

    msdw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_prefix (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    msdw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_row_a (
        .clk(clk), .we(r_we && !bank_reg), .waddr(i_reg), .wdata(new_cur),
        .raddr(add_reg), .rdata(ra_rdata)
    );
    msdw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_row_b (
        .clk(clk), .we(r_we && bank_reg), .waddr(i_reg), .wdata(new_cur),
        .raddr(add_reg), .rdata(rb_rdata)
    );
    msdw_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue (
        .clk(clk), .we(q_we), .waddr(tail_reg), .wdata(q_wdata),
        .raddr(q_addr), .rdata(q_rdata)
    );

    assign lo = (min_len_reg == 11'd0) ? 11'd1 : min_len_reg;
    assign value_ext = {{(64 - VALUE_WIDTH){s_tdata[VALUE_WIDTH-1]}},
                        s_tdata[VALUE_WIDTH-1:0]};
    assign psum_add = psum_reg + value_ext;
    assign p_val = paddr0_reg ? 64'sd0 : $signed(p_rdata);
    assign q_val = $signed(q_rdata[QW-1:CW]);
    assign q_idx = q_rdata[CW-1:0];
    assign cand = pi_reg + hv_reg;
    assign new_cur = (hnon_reg && (cand > curprev_reg)) ? cand : curprev_reg;
    assign q_wdata = {v_reg, add_reg};
    assign p_wdata = psum_add;

    always_comb
    begin
        if (k_reg == 11'd1)
        begin
            prev_val = 64'sd0;
        end
        else if ({{(XW-CW){1'b0}}, add_reg} < {{(XW-11){1'b0}}, lo})
        begin
            prev_val = msdw_pkg::SENTINEL;
        end
        else
        begin
            prev_val = bank_reg ? $signed(ra_rdata) : $signed(rb_rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_windows_reg <= 11'd1;
            min_len_reg     <= 11'd1;
            max_len_reg     <= 11'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msdw_pkg::REG_MAX_WINDOWS: max_windows_reg <= cfg_data;
                msdw_pkg::REG_MIN_LEN:     min_len_reg     <= cfg_data;
                msdw_pkg::REG_MAX_LEN:     max_len_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        psum_next    = psum_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        add_next     = add_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        k_next       = k_reg;
        bank_next    = bank_reg;
        v_next       = v_reg;
        pi_next      = pi_reg;
        hv_next      = hv_reg;
        hnon_next    = hnon_reg;
        curprev_next = curprev_reg;
        ans_next     = ans_reg;
        paddr0_next  = 1'b0;
        ovalid_next  = ovalid_reg && !m_tready;
        odata_next   = odata_reg;
        s_tready     = 1'b0;
        p_we         = 1'b0;
        p_waddr      = cnt_reg + CW'(1);
        p_raddr      = add_reg;
        r_we         = 1'b0;
        q_we         = 1'b0;
        q_addr       = tail_reg - CW'(1);
        n_load       = (cnt_reg < CW'(MAX_ELEMENTS)) ? cnt_reg + CW'(1) : cnt_reg;

        unique case (state_reg)
            msdw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (cnt_reg < CW'(MAX_ELEMENTS))
                    begin
                        p_we      = 1'b1;
                        psum_next = psum_add;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    if (s_tlast)
                    begin
                        n_next   = n_load;
                        k_next   = 11'd1;
                        ans_next = msdw_pkg::SENTINEL;
                        bank_next = 1'b0;
                        if ((max_windows_reg == 11'd0) ||
                            ({{(XW-CW){1'b0}}, n_load} < {{(XW-11){1'b0}}, lo}))
                        begin
                            state_next = msdw_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = msdw_pkg::ST_ROW;
                        end
                    end
                end
            end
            msdw_pkg::ST_ROW:
            begin
                i_next       = lo[CW-1:0];
                add_next     = '0;
                head_next    = '0;
                tail_next    = '0;
                curprev_next = msdw_pkg::SENTINEL;
                state_next   = msdw_pkg::ST_RD1;
            end
            msdw_pkg::ST_RD1:
            begin
                p_raddr     = add_reg;
                paddr0_next = (add_reg == '0);
                state_next  = msdw_pkg::ST_RD2;
            end
            msdw_pkg::ST_RD2:
            begin
                v_next     = prev_val - p_val;
                p_raddr    = i_reg;
                state_next = msdw_pkg::ST_PI;
            end
            msdw_pkg::ST_PI:
            begin
                pi_next    = $signed(p_rdata);
                state_next = msdw_pkg::ST_TCHK;
            end
            msdw_pkg::ST_TCHK:
            begin
                q_addr = tail_reg - CW'(1);
                if (tail_reg > head_reg)
                begin
                    state_next = msdw_pkg::ST_TCMP;
                end
                else
                begin
                    state_next = msdw_pkg::ST_PUSH;
                end
            end
            msdw_pkg::ST_TCMP:
            begin
                if (q_val <= v_reg)
                begin
                    tail_next  = tail_reg - CW'(1);
                    state_next = msdw_pkg::ST_TCHK;
                end
                else
                begin
                    state_next = msdw_pkg::ST_PUSH;
                end
            end
            msdw_pkg::ST_PUSH:
            begin
                q_we       = 1'b1;
                tail_next  = tail_reg + CW'(1);
                state_next = msdw_pkg::ST_HCHK;
            end
            msdw_pkg::ST_HCHK:
            begin
                q_addr = head_reg;
                if (tail_reg > head_reg)
                begin
                    state_next = msdw_pkg::ST_HCMP;
                end
                else
                begin
                    hnon_next  = 1'b0;
                    state_next = msdw_pkg::ST_UPD;
                end
            end
            msdw_pkg::ST_HCMP:
            begin
                if (({{(XW-CW){1'b0}}, q_idx} + {{(XW-11){1'b0}}, max_len_reg})
                    < {{(XW-CW){1'b0}}, i_reg})
                begin
                    head_next  = head_reg + CW'(1);
                    state_next = msdw_pkg::ST_HCHK;
                end
                else
                begin
                    hv_next    = q_val;
                    hnon_next  = 1'b1;
                    state_next = msdw_pkg::ST_UPD;
                end
            end
            msdw_pkg::ST_UPD:
            begin
                r_we         = 1'b1;
                curprev_next = new_cur;
                if (i_reg == n_reg)
                begin
                    if (new_cur > ans_reg)
                    begin
                        ans_next = new_cur;
                    end
                    if (k_reg == max_windows_reg)
                    begin
                        state_next = msdw_pkg::ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 11'd1;
                        bank_next  = !bank_reg;
                        state_next = msdw_pkg::ST_ROW;
                    end
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    add_next   = add_reg + CW'(1);
                    state_next = msdw_pkg::ST_RD1;
                end
            end
            msdw_pkg::ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = ans_reg;
                    cnt_next    = '0;
                    psum_next   = 64'sd0;
                    state_next  = msdw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msdw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= msdw_pkg::ST_IDLE;
            cnt_reg    <= '0;
            psum_reg   <= 64'sd0;
            ovalid_reg <= 1'b0;
            k_reg      <= 11'd1;
            bank_reg   <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            psum_reg   <= psum_next;
            ovalid_reg <= ovalid_next;
            k_reg      <= k_next;
            bank_reg   <= bank_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        add_reg     <= add_next;
        v_reg       <= v_next;
        pi_reg      <= pi_next;
        hv_reg      <= hv_next;
        hnon_reg    <= hnon_next;
        curprev_reg <= curprev_next;
        ans_reg     <= ans_next;
        paddr0_reg  <= paddr0_next;
        odata_reg   <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b000, odata_reg[52:0]};
    assign m_tuser  = (odata_reg == msdw_pkg::SENTINEL);

endmodule
`default_nettype wire

[rtl/msdw_ram.sv]
`default_nettype none
module msdw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
